>>> sv/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// shared types and constants of the byte ring buffer with burst transfers
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int BRB_DEPTH     = 1024;
   localparam int BRB_MAX_BURST = 8;
   localparam int BRB_LEVEL_W   = $clog2(BRB_DEPTH + 1);

   localparam int BRB_COUNT_W   = 4;
   localparam int BRB_DATA_W    = 64;
   localparam int BRB_LANES     = 8;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_NO_DATA  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_POP,
      S_POP_WAIT,
      S_DONE
   } state_type;

endpackage

>>> sv/brb_if.sv
// ----------------------------------------------------------------------------
// brb_req_if / brb_rsp_if
// valid/ready channels carrying the request and response transactions
// ----------------------------------------------------------------------------
interface brb_req_if
   import brb_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [BRB_COUNT_W-1:0] count;
   logic [BRB_DATA_W-1:0]  data;

   modport source (output valid, output kind, output count, output data, input ready);
   modport sink   (input valid, input kind, input count, input data, output ready);
endinterface

interface brb_rsp_if
   import brb_pkg::*;
   #(parameter int LEVEL_W = BRB_LEVEL_W)
   ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [BRB_COUNT_W-1:0] out_count;
   logic [BRB_DATA_W-1:0]  out_data;
   logic [LEVEL_W-1:0]     fill_level;

   modport source (output valid, output status, output out_count, output out_data,
                   output fill_level, input ready);
   modport sink   (input valid, input status, input out_count, input out_data,
                   input fill_level, output ready);
endinterface

>>> sv/byte_ring_buffer_burst_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_core
// circular byte fifo with all-or-nothing burst push and pop transactions
// ----------------------------------------------------------------------------
// Each request pushes or pops up to MAX_BURST bytes (larger counts saturate)
// and gives exactly one response with a status, the popped bytes (oldest in
// the low byte) and the fill level afterwards. A push that does not fit or a
// pop of more bytes than are held is refused and leaves the buffer unchanged.
// The bytes live in a single-port-write, single-port-read memory of DEPTH
// bytes that moves one byte per cycle. A refused or zero-count request goes
// from S_IDLE straight to S_DONE, a push runs through S_PUSH and a pop through
// S_POP and S_POP_WAIT (which covers the registered memory read); a new
// request is taken while the previous response still waits in the output
// register, and a full output register holds the block at the end of a request.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst_core
   import brb_pkg::*;
   #(
      parameter int DEPTH     = BRB_DEPTH,
      parameter int MAX_BURST = BRB_MAX_BURST
   )
   (
      input  logic      clock,
      input  logic      reset,
      brb_req_if.sink   req_bus,
      brb_rsp_if.source rsp_bus
   );

   localparam int AW      = $clog2(DEPTH);
   localparam int LEVEL_W = $clog2(DEPTH + 1);

   // state and request registers
   state_type              state_ff,  state_in;
   logic                   kind_ff,   kind_in;
   logic [BRB_COUNT_W-1:0] cnt_ff,    cnt_in;
   logic [BRB_DATA_W-1:0]  data_ff,   data_in;
   status_type             status_ff, status_in;
   logic [BRB_COUNT_W-1:0] step_ff,   step_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [2:0]             lane_ff,   lane_in;
   logic [BRB_DATA_W-1:0]  acc_ff,    acc_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [LEVEL_W-1:0]     held_ff,   held_in;

   // response registers
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [BRB_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [BRB_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [LEVEL_W-1:0]     rsp_level_ff, rsp_level_in;

   // byte store
   logic [7:0]             store [DEPTH];
   logic                   mem_we;
   logic [7:0]             mem_wdata;
   logic [7:0]             mem_q;

   logic [BRB_COUNT_W-1:0] sat_cnt;
   logic [LEVEL_W-1:0]     room;
   logic [LEVEL_W-1:0]     held_after;
   logic                   last_step;
   logic                   rsp_free;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
      advance = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      sat_cnt    = (req_bus.count > BRB_COUNT_W'(MAX_BURST)) ?
                   BRB_COUNT_W'(MAX_BURST) : req_bus.count;
      room       = LEVEL_W'(DEPTH) - held_ff;
      last_step  = ((step_ff + BRB_COUNT_W'(1)) == cnt_ff);
      rsp_free   = !rsp_valid_ff || rsp_bus.ready;

      held_after = held_ff;
      if (status_ff == ST_OK) begin
         if (kind_ff == KIND_PUSH) begin
            held_after = held_ff + LEVEL_W'(cnt_ff);
         end else begin
            held_after = held_ff - LEVEL_W'(cnt_ff);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      cnt_in        = cnt_ff;
      data_in       = data_ff;
      status_in     = status_ff;
      step_in       = step_ff;
      rd_pend_in    = 1'b0;
      lane_in       = lane_ff;
      acc_in        = acc_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_level_in  = rsp_level_ff;
      mem_we        = 1'b0;
      mem_wdata     = data_ff[{step_ff[2:0], 3'b000} +: 8];
      req_bus.ready = (state_ff == S_IDLE);

      // capture of the byte read in the previous cycle
      if (rd_pend_ff) begin
         acc_in[{lane_ff, 3'b000} +: 8] = mem_q;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               kind_in   = req_bus.kind;
               cnt_in    = sat_cnt;
               data_in   = req_bus.data;
               step_in   = '0;
               acc_in    = '0;
               status_in = ST_OK;
               if (req_bus.kind == KIND_PUSH) begin
                  if (LEVEL_W'(sat_cnt) > room) begin
                     status_in = ST_NO_SPACE;
                  end
               end else begin
                  if (LEVEL_W'(sat_cnt) > held_ff) begin
                     status_in = ST_NO_DATA;
                  end
               end
               if (status_in != ST_OK || sat_cnt == '0) begin
                  state_in = S_DONE;
               end else if (req_bus.kind == KIND_PUSH) begin
                  state_in = S_PUSH;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_PUSH: begin
            mem_we    = 1'b1;
            wr_ptr_in = advance(wr_ptr_ff);
            step_in   = step_ff + BRB_COUNT_W'(1);
            if (last_step) begin
               state_in = S_DONE;
            end
         end
         S_POP: begin
            rd_pend_in = 1'b1;
            lane_in    = step_ff[2:0];
            rd_ptr_in  = advance(rd_ptr_ff);
            step_in    = step_ff + BRB_COUNT_W'(1);
            if (last_step) begin
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = (status_ff == ST_OK && kind_ff == KIND_POP) ? cnt_ff : '0;
               rsp_data_in   = acc_ff;
               rsp_level_in  = held_after;
               held_in       = held_after;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      cnt_ff        <= cnt_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      step_ff       <= step_in;
      lane_ff       <= lane_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_level_ff  <= rsp_level_in;
   end

   // byte store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_ptr_ff] <= mem_wdata;
      end
      mem_q <= store[rd_ptr_ff];
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.out_count  = rsp_count_ff;
   assign rsp_bus.out_data   = rsp_data_ff;
   assign rsp_bus.fill_level = rsp_level_ff;

endmodule

>>> bench/byte_ring_buffer_burst_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_core_tb
// self-checking bench for the burst byte ring buffer
// ----------------------------------------------------------------------------
// Drives push and pop transactions over the request channel and mirrors the
// buffer contents, pointers and fill level in a scoreboard class, which works
// out the response of every accepted request and checks each response as it
// leaves. A short directed run covers zero counts, saturated counts, refusals
// and extreme data; random traffic then sweeps the fill level between empty
// and full so that the pointers wrap, under three phases of sender and
// receiver idling.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst_core_tb;
   import brb_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 230;
   localparam int TAIL_CYCLES  = 40;

   class byte_fifo_mirror;
      typedef struct {
         status_type             status;
         logic [BRB_COUNT_W-1:0] out_count;
         logic [BRB_DATA_W-1:0]  out_data;
         logic [BRB_LEVEL_W-1:0] fill_level;
      } reply_type;

      logic [7:0]  store [BRB_DEPTH];
      int unsigned rd_ptr;
      int unsigned wr_ptr;
      int unsigned held;
      reply_type   awaited_replies [$];
      int          mismatches;

      function void note_request(kind_type op, logic [BRB_COUNT_W-1:0] n,
                                 logic [BRB_DATA_W-1:0] payload);
         reply_type   r;
         int unsigned len;
         len = (n > BRB_MAX_BURST) ? BRB_MAX_BURST : n;
         r.status = ST_OK;
         r.out_count = '0;
         r.out_data = '0;
         if (op == KIND_PUSH) begin
            if (len > BRB_DEPTH - held) begin
               r.status = ST_NO_SPACE;
            end else begin
               for (int i = 0; i < len; i++) begin
                  store[wr_ptr] = payload[8*i +: 8];
                  wr_ptr = (wr_ptr + 1) % BRB_DEPTH;
               end
               held += len;
            end
         end else begin
            if (len > held) begin
               r.status = ST_NO_DATA;
            end else begin
               for (int i = 0; i < len; i++) begin
                  r.out_data[8*i +: 8] = store[rd_ptr];
                  rd_ptr = (rd_ptr + 1) % BRB_DEPTH;
               end
               held -= len;
               r.out_count = BRB_COUNT_W'(len);
            end
         end
         r.fill_level = BRB_LEVEL_W'(held);
         awaited_replies.push_back(r);
      endfunction

      function void check_response(logic [1:0] st, logic [BRB_COUNT_W-1:0] n,
                                   logic [BRB_DATA_W-1:0] dat,
                                   logic [BRB_LEVEL_W-1:0] lvl);
         reply_type r;
         if (awaited_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response st %0d cnt %0d data %h lvl %0d",
                        $realtime, st, n, dat, lvl);
            return;
         end
         r = awaited_replies.pop_front();
         if (st !== r.status || n !== r.out_count || dat !== r.out_data ||
             lvl !== r.fill_level) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: exp/got st %0d/%0d cnt %0d/%0d data %h/%h lvl %0d/%0d",
                        $realtime, r.status, st, r.out_count, n, r.out_data, dat,
                        r.fill_level, lvl);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   brb_req_if req_bus ();
   brb_rsp_if rsp_bus ();

   byte_ring_buffer_burst_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   byte_fifo_mirror mirror = new();

   int send_idle_pct = 23;
   int rsp_idle_pct  = 70;
   int quiet_cycles  = 0;
   bit filling       = 1'b1;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            mirror.note_request(kind_type'(req_bus.kind), req_bus.count, req_bus.data);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            mirror.check_response(rsp_bus.status, rsp_bus.out_count, rsp_bus.out_data,
                                  rsp_bus.fill_level);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(input kind_type op, input logic [BRB_COUNT_W-1:0] n,
                               input logic [BRB_DATA_W-1:0] payload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= op;
      req_bus.count <= n;
      req_bus.data  <= payload;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // hold the sender until every response has come back
   task automatic await_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (mirror.awaited_replies.size() != 0);
   endtask

   task automatic send_random(input int items);
      kind_type               op;
      logic [BRB_COUNT_W-1:0] n;
      int                     sel;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < 2)
            await_drain();
         op = ($urandom_range(99) < (filling ? 78 : 22)) ? KIND_PUSH : KIND_POP;
         sel = $urandom_range(99);
         if (sel < 6)
            n = '0;
         else if (sel < 12)
            n = BRB_COUNT_W'($urandom_range(15, BRB_MAX_BURST + 1));
         else if (sel < 55)
            n = BRB_COUNT_W'(BRB_MAX_BURST);
         else
            n = BRB_COUNT_W'($urandom_range(BRB_MAX_BURST - 1, 1));
         send_request(op, n, {$urandom, $urandom});
         // sweep the level between empty and full
         if (mirror.held >= BRB_DEPTH - 4)
            filling = 1'b0;
         else if (mirror.held <= 4)
            filling = 1'b1;
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_PUSH;
      req_bus.count <= '0;
      req_bus.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_PUSH, 4'd0, 64'hdead_beef_0bad_f00d);
      send_request(KIND_POP,  4'd0, '0);
      send_request(KIND_POP,  4'd1, '0);
      send_request(KIND_PUSH, 4'd8, 64'hffff_ffff_ffff_ffff);
      send_request(KIND_PUSH, 4'd8, 64'h0);
      send_request(KIND_PUSH, 4'd15, 64'h0123_4567_89ab_cdef);
      send_request(KIND_PUSH, 4'd3, 64'hfeed_face_cafe_1a2b);
      send_request(KIND_POP,  4'd8, {$urandom, $urandom});
      send_request(KIND_POP,  4'd15, '0);
      send_request(KIND_POP,  4'd9, '0);
      send_request(KIND_POP,  4'd4, '0);
      send_request(KIND_POP,  4'd3, '0);
      send_request(KIND_POP,  4'd0, '0);
      send_request(KIND_PUSH, 4'd1, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(KIND_PUSH, 4'd7, 64'h5555_5555_5555_5555);
      send_request(KIND_POP,  4'd8, '0);
      send_request(KIND_PUSH, 4'd8, {$urandom, $urandom});
      send_request(KIND_POP,  4'd1, '0);
      send_request(KIND_POP,  4'd7, '0);

      send_random(PHASE_ITEMS);
      await_drain();
      send_idle_pct = 70;
      rsp_idle_pct  = 23;
      send_random(PHASE_ITEMS);
      await_drain();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      send_random(PHASE_ITEMS);

      req_bus.valid <= 1'b0;
      while (mirror.awaited_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.awaited_replies.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
sv/brb_pkg.sv
sv/brb_if.sv
sv/byte_ring_buffer_burst_core.sv
bench/byte_ring_buffer_burst_core_tb.sv
